// ----- rtl/core/varying_register_packer_assert.svh -----
// Assertion helpers for the packer RTL, included by the controller.
// Both expect clk and rst_n in scope.
`ifndef VARYING_REGISTER_PACKER_ASSERT_SVH
`define VARYING_REGISTER_PACKER_ASSERT_SVH

// Same-cycle implication.
`define VRP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define VRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/vrp_pkg.sv -----
package vrp_pkg;

    localparam int GRID_ROWS = 32;
    localparam int COLS      = 4;
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int CNT_W     = ROW_W + 1;
    localparam int LEN_W     = 6;
    localparam int WID_W     = 3;
    localparam int STAT_W    = 2;
    localparam int SROW_W    = 6;
    localparam int SCOL_W    = 2;
    localparam int USED_W    = 7;

    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NO_SPACE  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_BAD_WIDTH = 2'd2;

    localparam logic KIND_CLEAR = 1'b0;

    localparam logic [COLS-1:0] MASK_UPPER_PAIR = 4'b1100;
    localparam logic [SCOL_W-1:0] COL_UPPER_PAIR = 2'd2;

    typedef struct packed {
        logic             kind;
        logic [LEN_W-1:0] row_count;
        logic [WID_W-1:0] col_width;
    } request_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SROW_W-1:0] start_row;
        logic [SCOL_W-1:0] start_col;
        logic [USED_W-1:0] used_rows;
    } result_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_UP_INIT,
        OP_UP_STEP,
        OP_DOWN_STEP,
        OP_SEEK_INIT,
        OP_SEEK_STEP,
        OP_MARK
    } op_t;

    typedef struct packed {
        op_t  op;
        logic set_nospace;
        logic set_bad;
    } cmd_t;

    typedef struct packed {
        logic is_clear;
        logic w_bad;
        logic w_one;
        logic w_two;
        logic n_zero;
        logic fit;
        logic free_cell;
        logic window_hit;
        logic last_row;
        logic first_row;
        logic mark_last;
    } stat_t;

endpackage

// ----- rtl/core/vrp_dpath.sv -----
module vrp_dpath
    import vrp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  request_t request,
    input  cmd_t     cmd,
    output stat_t    stat,
    output result_t  result
);

    request_t          req_reg;
    logic [COLS-1:0]   grid_reg [GRID_ROWS];
    logic [CNT_W-1:0]  free_reg [COLS];
    logic [CNT_W-1:0]  used_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [CNT_W-1:0]  run_reg;
    logic [LEN_W-1:0]  left_reg;
    logic [COLS-1:0]   mask_reg;
    logic [ROW_W-1:0]  srow_reg;
    logic [SCOL_W-1:0] scol_reg;
    logic [STAT_W-1:0] status_reg;

    logic [COLS-1:0]   cur_row;
    logic [COLS-1:0]   width_mask;
    logic [USED_W-1:0] n_ext;
    logic [USED_W-1:0] run_inc;
    logic [CNT_W-1:0]  run_next;
    logic [SCOL_W-1:0] cand;
    logic              free_cell;
    logic              last_row;

    assign cur_row   = grid_reg[row_reg];
    assign free_cell = (cur_row & mask_reg) == '0;
    assign n_ext     = USED_W'(req_reg.row_count);
    assign run_inc   = USED_W'(run_reg) + USED_W'(1);
    assign run_next  = free_cell ? CNT_W'(run_inc) : '0;
    assign last_row  = row_reg == ROW_W'(GRID_ROWS - 1);

    always_comb
    begin
        case (req_reg.col_width)
            3'd2:    width_mask = 4'b0011;
            3'd3:    width_mask = 4'b0111;
            3'd4:    width_mask = 4'b1111;
            default: width_mask = 4'b0000;
        endcase
    end

    // Width-1 column pick: a later column wins only if it fits and is strictly fuller.
    always_comb
    begin
        cand = '0;
        for (int x = 1; x < COLS; x++)
        begin
            if (USED_W'(free_reg[x]) >= n_ext && free_reg[x] < free_reg[cand])
                cand = SCOL_W'(x);
        end
    end

    always_comb
    begin
        stat.is_clear   = req_reg.kind == KIND_CLEAR;
        stat.w_one      = req_reg.col_width == 3'd1;
        stat.w_two      = req_reg.col_width == 3'd2;
        stat.w_bad      = !stat.w_one && width_mask == '0;
        stat.n_zero     = req_reg.row_count == '0;
        stat.fit        = USED_W'(free_reg[cand]) >= n_ext;
        stat.free_cell  = free_cell;
        stat.window_hit = free_cell && run_inc == n_ext;
        stat.last_row   = last_row;
        stat.first_row  = row_reg == '0;
        stat.mark_last  = left_reg == LEN_W'(1) || last_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg    <= '0;
            for (int r = 0; r < GRID_ROWS; r++)
                grid_reg[r] <= '0;
            for (int c = 0; c < COLS; c++)
                free_reg[c] <= CNT_W'(GRID_ROWS);
            used_reg   <= '0;
            row_reg    <= '0;
            run_reg    <= '0;
            left_reg   <= '0;
            mask_reg   <= '0;
            srow_reg   <= '0;
            scol_reg   <= '0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    req_reg    <= request;
                    status_reg <= STATUS_OK;
                    srow_reg   <= '0;
                    scol_reg   <= '0;
                end
                OP_CLEAR:
                begin
                    for (int r = 0; r < GRID_ROWS; r++)
                        grid_reg[r] <= '0;
                    for (int c = 0; c < COLS; c++)
                        free_reg[c] <= CNT_W'(GRID_ROWS);
                    used_reg <= '0;
                end
                OP_UP_INIT:
                begin
                    row_reg  <= '0;
                    run_reg  <= '0;
                    mask_reg <= width_mask;
                end
                OP_UP_STEP:
                begin
                    if (stat.window_hit)
                    begin
                        srow_reg <= row_reg - run_reg[ROW_W-1:0];
                        row_reg  <= row_reg - run_reg[ROW_W-1:0];
                        left_reg <= req_reg.row_count;
                    end
                    else if (last_row)
                    begin
                        // fall back to columns 2-3, scanning down from the last row
                        run_reg  <= '0;
                        mask_reg <= MASK_UPPER_PAIR;
                    end
                    else
                    begin
                        row_reg <= row_reg + ROW_W'(1);
                        run_reg <= run_next;
                    end
                end
                OP_DOWN_STEP:
                begin
                    if (stat.window_hit)
                    begin
                        srow_reg <= row_reg;
                        scol_reg <= COL_UPPER_PAIR;
                        left_reg <= req_reg.row_count;
                    end
                    else
                    begin
                        row_reg <= row_reg - ROW_W'(1);
                        run_reg <= run_next;
                    end
                end
                OP_SEEK_INIT:
                begin
                    row_reg  <= '0;
                    mask_reg <= COLS'(1) << cand;
                    scol_reg <= cand;
                end
                OP_SEEK_STEP:
                begin
                    if (free_cell)
                    begin
                        srow_reg <= row_reg;
                        left_reg <= req_reg.row_count;
                    end
                    else
                        row_reg <= row_reg + ROW_W'(1);
                end
                OP_MARK:
                begin
                    grid_reg[row_reg] <= cur_row | mask_reg;
                    if (cur_row == '0)
                        used_reg <= used_reg + CNT_W'(1);
                    for (int c = 0; c < COLS; c++)
                    begin
                        if (mask_reg[c] && !cur_row[c])
                            free_reg[c] <= free_reg[c] - CNT_W'(1);
                    end
                    row_reg  <= row_reg + ROW_W'(1);
                    left_reg <= left_reg - LEN_W'(1);
                end
                default:
                begin
                end
            endcase

            if (cmd.set_nospace)
            begin
                status_reg <= STATUS_NO_SPACE;
                srow_reg   <= '0;
                scol_reg   <= '0;
            end
            if (cmd.set_bad)
            begin
                status_reg <= STATUS_BAD_WIDTH;
                srow_reg   <= '0;
                scol_reg   <= '0;
            end
        end
    end

    assign result.status    = status_reg;
    assign result.start_row = SROW_W'(srow_reg);
    assign result.start_col = scol_reg;
    assign result.used_rows = USED_W'(used_reg);

endmodule

// ----- rtl/core/vrp_ctrl.sv -----
module vrp_ctrl
    import vrp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy,
    output logic  done
);

    `include "varying_register_packer_assert.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_UP,
        ST_DOWN,
        ST_SEEK,
        ST_MARK,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;
    logic   accept;

    assign accept = start && !busy_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd.op          = OP_NONE;
        cmd.set_nospace = 1'b0;
        cmd.set_bad     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_DONE;
                if (stat.is_clear)
                    cmd.op = OP_CLEAR;
                else if (stat.w_bad)
                    cmd.set_bad = 1'b1;
                else if (stat.w_one)
                begin
                    if (stat.fit)
                    begin
                        cmd.op     = OP_SEEK_INIT;
                        state_next = ST_SEEK;
                    end
                    else
                        cmd.set_nospace = 1'b1;
                end
                else if (!stat.n_zero)
                begin
                    cmd.op     = OP_UP_INIT;
                    state_next = ST_UP;
                end
            end
            ST_UP:
            begin
                cmd.op = OP_UP_STEP;
                if (stat.window_hit)
                    state_next = ST_MARK;
                else if (stat.last_row)
                begin
                    if (stat.w_two)
                        state_next = ST_DOWN;
                    else
                    begin
                        cmd.set_nospace = 1'b1;
                        state_next      = ST_DONE;
                    end
                end
            end
            ST_DOWN:
            begin
                cmd.op = OP_DOWN_STEP;
                if (stat.window_hit)
                    state_next = ST_MARK;
                else if (stat.first_row)
                begin
                    cmd.set_nospace = 1'b1;
                    state_next      = ST_DONE;
                end
            end
            ST_SEEK:
            begin
                cmd.op = OP_SEEK_STEP;
                if (stat.free_cell)
                    state_next = stat.n_zero ? ST_DONE : ST_MARK;
                else if (stat.last_row)
                    state_next = ST_DONE;   // column full, zero rows asked
            end
            ST_MARK:
            begin
                cmd.op = OP_MARK;
                if (stat.mark_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= state_next != ST_IDLE;
            done_reg  <= state_next == ST_DONE;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    `VRP_ASSERT_NOW(a_done_while_busy, done, busy, "done strobe outside a busy period")
    `VRP_ASSERT_NEXT(a_done_single, done, !done, "done held longer than one cycle")
    `VRP_ASSERT_NEXT(a_done_releases, done, !busy, "busy not released after done")
    `VRP_ASSERT_NEXT(a_accept_busy, accept, busy && !done, "accepted item not marked busy")

endmodule

// ----- rtl/core/varying_register_packer.sv -----
// Varying register packer: GRID_ROWS x 4 occupancy grid, one request at a time.
// Timing: a clear or a rejected request goes from accept through decode to done;
// a placement also scans rows (up, then down for width 2) or seeks a column, and
// marks one row per cycle. Throughput: the next start is taken the cycle after done.
// Busy holds off a new request until the current one has finished.
// Reset (rst_n low, async): grid empty, idle, no result pending; results cannot stall.
module varying_register_packer
    import vrp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  request_t request,
    output logic     busy,
    output logic     done,
    output result_t  result
);

    // Controller sequences decode, scan, seek and mark phases; the datapath
    // holds the grid, per-column free counts, the used-row count and the
    // result registers, and reports hit/boundary status back each cycle.
    cmd_t  cmd;
    stat_t stat;

    vrp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // result stays stable from done until the next accepted item
    vrp_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

endmodule
